[rtl/core/iap_pkg.sv]
// Package for the telecontrol data unit object parser.
// Holds the result record, object format decode, and field codes.
// No dependencies.
`default_nettype none

package iap_pkg;

  localparam logic [1:0] RK_OBJECT = 2'd0;
  localparam logic [1:0] RK_OK     = 2'd1;
  localparam logic [1:0] RK_SHORT  = 2'd2;

  localparam logic [2:0] VK_NONE   = 3'd0;
  localparam logic [2:0] VK_SINGLE = 3'd1;
  localparam logic [2:0] VK_DOUBLE = 3'd2;
  localparam logic [2:0] VK_NORM   = 3'd3;
  localparam logic [2:0] VK_SCALED = 3'd4;
  localparam logic [2:0] VK_FLOAT  = 3'd5;

  localparam logic [7:0] T_SP    = 8'd1;
  localparam logic [7:0] T_DP    = 8'd3;
  localparam logic [7:0] T_ME_NA = 8'd9;
  localparam logic [7:0] T_ME_NB = 8'd11;
  localparam logic [7:0] T_ME_NC = 8'd13;
  localparam logic [7:0] T_SP_TB = 8'd30;
  localparam logic [7:0] T_DP_TB = 8'd31;
  localparam logic [7:0] T_ME_TF = 8'd34;

  localparam logic [3:0] HDR_LEN  = 4'd6;
  localparam logic [3:0] MIN_UNIT = 4'd9;
  localparam logic [2:0] ADDR_LEN = 3'd3;
  localparam logic [2:0] TAG_LEN  = 3'd7;

  localparam logic [3:0] POS_TYPE   = 4'd0;
  localparam logic [3:0] POS_VSQ    = 4'd1;
  localparam logic [3:0] POS_COT    = 4'd2;
  localparam logic [3:0] POS_CA_LO  = 4'd4;
  localparam logic [3:0] POS_CA_HI  = 4'd5;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = 2;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  type_code;
    logic [5:0]  cause_code;
    logic [15:0] station_address;
    logic        sequence_mode;
    logic [23:0] object_address;
    logic [2:0]  value_kind;
    logic [31:0] object_value;
    logic        last_result;
  } iap_result_t;

  typedef struct packed {
    logic a;
    logic b;
  } iap_push_t;

  typedef struct packed {
    logic [2:0] len;
    logic [2:0] kind;
    logic [2:0] skip;
  } iap_fmt_t;

  function automatic iap_fmt_t iap_object_format(input logic [7:0] t, input logic seq);
    iap_fmt_t f;
    f = '{len: 3'd0, kind: VK_NONE, skip: 3'd0};
    if (seq) begin
      unique case (t)
        T_SP:    f = '{len: 3'd1, kind: VK_SINGLE, skip: 3'd0};
        T_DP:    f = '{len: 3'd1, kind: VK_DOUBLE, skip: 3'd0};
        T_ME_NA: f = '{len: 3'd3, kind: VK_NORM,   skip: 3'd0};
        T_ME_NB: f = '{len: 3'd3, kind: VK_SCALED, skip: 3'd0};
        T_ME_NC: f = '{len: 3'd5, kind: VK_FLOAT,  skip: 3'd0};
        default: f = '{len: 3'd1, kind: VK_NONE,   skip: 3'd0};
      endcase
    end else begin
      unique case (t)
        T_SP:    f = '{len: 3'd1, kind: VK_SINGLE, skip: 3'd0};
        T_SP_TB: f = '{len: 3'd1, kind: VK_SINGLE, skip: TAG_LEN};
        T_DP:    f = '{len: 3'd1, kind: VK_DOUBLE, skip: 3'd0};
        T_DP_TB: f = '{len: 3'd1, kind: VK_DOUBLE, skip: TAG_LEN};
        T_ME_NA: f = '{len: 3'd3, kind: VK_NORM,   skip: 3'd0};
        T_ME_NB: f = '{len: 3'd3, kind: VK_SCALED, skip: 3'd0};
        T_ME_NC: f = '{len: 3'd5, kind: VK_FLOAT,  skip: 3'd0};
        T_ME_TF: f = '{len: 3'd5, kind: VK_FLOAT,  skip: TAG_LEN};
        default: f = '{len: 3'd0, kind: VK_NONE,   skip: 3'd1};
      endcase
    end
    return f;
  endfunction

  function automatic iap_result_t iap_make_result(
    input logic [1:0]  rk,
    input logic [7:0]  t,
    input logic [5:0]  cot,
    input logic [15:0] ca,
    input logic        seq,
    input logic [23:0] addr,
    input logic [2:0]  vk,
    input logic [31:0] value,
    input logic        last
  );
    iap_result_t r;
    r.result_kind     = rk;
    r.type_code       = t;
    r.cause_code      = cot;
    r.station_address = ca;
    r.sequence_mode   = seq;
    r.object_address  = addr;
    r.value_kind      = vk;
    r.object_value    = value;
    r.last_result     = last;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/iap_parser.sv]
// Byte-at-a-time parser state: header fields and per-object progress.
// Produces up to two results per accepted byte. Depends on iap_pkg.
`default_nettype none

module iap_parser (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 step,
  input  wire [7:0]           data_byte,
  input  wire                 final_byte,
  output iap_pkg::iap_push_t  push,
  output iap_pkg::iap_result_t res_a,
  output iap_pkg::iap_result_t res_b
);
  import iap_pkg::*;

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  type_r, type_nxt;
  logic        seq_r, seq_nxt;
  logic [6:0]  objs_r, objs_nxt;
  logic [5:0]  cause_r, cause_nxt;
  logic [15:0] station_r, station_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [31:0] val_r, val_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [2:0]  skip_r, skip_nxt;
  logic        vphase_r, vphase_nxt;

  iap_fmt_t    fmt;
  logic [23:0] addr_new;
  logic [31:0] val_ins;
  logic [31:0] val_new;
  logic [2:0]  fcnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      type_r    <= '0;
      seq_r     <= 1'b0;
      objs_r    <= '0;
      cause_r   <= '0;
      station_r <= '0;
      addr_r    <= '0;
      val_r     <= '0;
      fcnt_r    <= '0;
      skip_r    <= '0;
      vphase_r  <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      type_r    <= type_nxt;
      seq_r     <= seq_nxt;
      objs_r    <= objs_nxt;
      cause_r   <= cause_nxt;
      station_r <= station_nxt;
      addr_r    <= addr_nxt;
      val_r     <= val_nxt;
      fcnt_r    <= fcnt_nxt;
      skip_r    <= skip_nxt;
      vphase_r  <= vphase_nxt;
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    type_nxt    = type_r;
    seq_nxt     = seq_r;
    objs_nxt    = objs_r;
    cause_nxt   = cause_r;
    station_nxt = station_r;
    addr_nxt    = addr_r;
    val_nxt     = val_r;
    fcnt_nxt    = fcnt_r;
    skip_nxt    = skip_r;
    vphase_nxt  = vphase_r;
    push        = '0;
    res_a       = '0;
    res_b       = '0;

    fmt      = iap_object_format(type_r, seq_r);
    fcnt_inc = fcnt_r + 3'd1;
    addr_new = addr_r | ({16'd0, data_byte} << {fcnt_r[1:0], 3'b000});
    val_ins  = val_r | ({24'd0, data_byte} << {fcnt_r[1:0], 3'b000});
    val_new  = val_r;
    case (fmt.kind) inside
      VK_SINGLE: val_new = {31'd0, data_byte[0]};
      VK_DOUBLE: val_new = {30'd0, data_byte[1:0]};
      VK_NORM, VK_SCALED: begin
        if (fcnt_r < 3'd2) val_new = val_ins;
      end
      VK_FLOAT: begin
        if (fcnt_r < 3'd4) val_new = val_ins;
      end
      default: val_new = val_r;
    endcase

    if (step) begin
      if (pos_r < HDR_LEN) begin
        unique case (pos_r)
          POS_TYPE: type_nxt = data_byte;
          POS_VSQ: begin
            seq_nxt  = data_byte[7];
            objs_nxt = data_byte[6:0];
          end
          POS_COT:   cause_nxt = data_byte[5:0];
          POS_CA_LO: station_nxt = {station_r[15:8], data_byte};
          POS_CA_HI: station_nxt = {data_byte, station_r[7:0]};
          default: ;
        endcase
      end else if (objs_r != 7'd0) begin
        if (skip_r != 3'd0) begin
          skip_nxt = skip_r - 3'd1;
        end else if (!vphase_r) begin
          addr_nxt = addr_new;
          fcnt_nxt = fcnt_inc;
          if (fcnt_inc >= ADDR_LEN) begin
            fcnt_nxt   = '0;
            val_nxt    = '0;
            vphase_nxt = 1'b1;
            if (!seq_r && fmt.len == 3'd0) begin
              push.a     = 1'b1;
              res_a      = iap_make_result(RK_OBJECT, type_r, cause_r, station_r, seq_r,
                                           addr_new, fmt.kind, 32'd0, 1'b0);
              objs_nxt   = objs_r - 7'd1;
              addr_nxt   = '0;
              vphase_nxt = 1'b0;
              skip_nxt   = fmt.skip;
            end
          end
        end else begin
          val_nxt  = val_new;
          fcnt_nxt = fcnt_inc;
          if (fcnt_inc >= fmt.len) begin
            push.a   = 1'b1;
            res_a    = iap_make_result(RK_OBJECT, type_r, cause_r, station_r, seq_r, addr_r,
                                       fmt.kind, (fmt.kind == VK_NONE) ? 32'd0 : val_new,
                                       1'b0);
            objs_nxt = objs_r - 7'd1;
            fcnt_nxt = '0;
            val_nxt  = '0;
            if (seq_r) begin
              addr_nxt = addr_r + 24'd1;
            end else begin
              addr_nxt   = '0;
              vphase_nxt = 1'b0;
              skip_nxt   = fmt.skip;
            end
          end
        end
      end

      if (pos_r < MIN_UNIT) pos_nxt = pos_r + 4'd1;

      if (final_byte) begin
        push.b = 1'b1;
        if (pos_nxt < MIN_UNIT) begin
          res_b = iap_make_result(RK_SHORT, 8'd0, 6'd0, 16'd0, 1'b0, 24'd0, VK_NONE,
                                  32'd0, 1'b1);
        end else begin
          res_b = iap_make_result(RK_OK, type_r, cause_r, station_r, seq_r, 24'd0, VK_NONE,
                                  32'd0, 1'b1);
        end
        pos_nxt     = '0;
        type_nxt    = '0;
        seq_nxt     = 1'b0;
        objs_nxt    = '0;
        cause_nxt   = '0;
        station_nxt = '0;
        addr_nxt    = '0;
        val_nxt     = '0;
        fcnt_nxt    = '0;
        skip_nxt    = '0;
        vphase_nxt  = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/iap_out_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one.
// Depends on iap_pkg.
`default_nettype none

module iap_out_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  iap_pkg::iap_push_t   push,
  input  iap_pkg::iap_result_t res_a,
  input  iap_pkg::iap_result_t res_b,
  output logic                 room,
  output logic                 out_valid,
  input  wire                  out_ready,
  output iap_pkg::iap_result_t out_res
);
  import iap_pkg::*;

  iap_result_t       mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_r, wr_nxt;
  logic [Q_AW-1:0]   rd_r, rd_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;
  logic [Q_AW-1:0]   wr_b;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rd_r];
  assign room      = (cnt_r <= (Q_AW+1)'(Q_DEPTH - 2));
  assign wr_b      = push.a ? (wr_r + 1'b1) : wr_r;

  always_comb begin
    wr_nxt  = wr_r + Q_AW'(push.a) + Q_AW'(push.b);
    rd_nxt  = rd_r + Q_AW'(pop);
    cnt_nxt = cnt_r + (Q_AW+1)'(push.a) + (Q_AW+1)'(push.b) - (Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.a) mem[wr_r] <= res_a;
    if (push.b) mem[wr_b] <= res_b;
  end

endmodule

`default_nettype wire

[rtl/core/iec104_asdu_object_parser.sv]
// A result is queued when the byte that completes it is taken. Throughput: one byte per
// cycle while in_tready is high; a final byte may queue two results (object, then status).
// The four-entry result queue holds in_tready low while fewer than two entries are free.
// Reset: synchronous, active low; clears header, object progress and the result queue.
// Top level of the data unit object parser; instantiates iap_parser and iap_out_fifo.
`default_nettype none

module iec104_asdu_object_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // data_byte
  input  wire         in_tlast,   // final_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [87:0] out_tdata,  // type_code, cause_code, station_address, sequence_mode,
                                  // object_address, object_value, zero pad
  output logic [4:0]  out_tuser,  // result_kind, value_kind
  output logic        out_tlast   // last_result
);
  import iap_pkg::*;

  iap_push_t   push;
  iap_result_t res_a;
  iap_result_t res_b;
  iap_result_t out_res;
  logic        room;
  logic        step;

  assign in_tready = room;
  assign step      = in_tvalid && room;

  iap_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .data_byte  (in_tdata),
    .final_byte (in_tlast),
    .push       (push),
    .res_a      (res_a),
    .res_b      (res_b)
  );

  iap_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {1'b0, out_res.object_value, out_res.object_address,
                      out_res.sequence_mode, out_res.station_address,
                      out_res.cause_code, out_res.type_code};
  assign out_tuser = {out_res.value_kind, out_res.result_kind};
  assign out_tlast = out_res.last_result;

endmodule

`default_nettype wire

[rtl/core/iap_checker.sv]
// Port-level checks on the result channel of the data unit object parser.
// Bound to iec104_asdu_object_parser; depends on iap_pkg.
`default_nettype none

module iap_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [87:0] out_tdata,
  input wire [4:0]  out_tuser,
  input wire        out_tlast
);
  import iap_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result changed while stalled");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser[1:0] != RK_OBJECT)))
    else $error("last flag does not match status result");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] == RK_OBJECT || out_tuser[1:0] == RK_OK
      || out_tuser[1:0] == RK_SHORT))
    else $error("unknown result kind");

  a_short_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == RK_SHORT |-> out_tdata == '0 && out_tuser[4:2] == VK_NONE)
    else $error("short unit result carries data");

  a_ok_no_object: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == RK_OK |-> out_tdata[87:31] == '0
      && out_tuser[4:2] == VK_NONE)
    else $error("status result carries object fields");

endmodule

bind iec104_asdu_object_parser iap_checker u_iap_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
